>>> hw/rtl/ttsp_pkg.sv
// shared types and constants of the transposition table store/probe unit
package ttsp_pkg;

  localparam int unsigned HashW  = 64;
  localparam int unsigned CountW = 17;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_PROBE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_CMP,
    ST_ZERO
  } state_e;

  // one table slot, 128 bits
  typedef struct packed {
    logic        [7:0]  age;
    logic        [7:0]  kind;
    logic        [15:0] move;
    logic signed [15:0] score;
    logic signed [15:0] depth;
    logic        [63:0] key;
  } entry_t;

  typedef struct packed {
    op_e                op;
    logic        [7:0]  generation;
    logic        [7:0]  node_kind;
    logic        [15:0] best_move;
    logic signed [15:0] score;
    logic signed [15:0] search_depth;
    logic        [63:0] hash;
  } req_t;

  typedef struct packed {
    logic              start;
    logic [HashW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] rem;
  } div_rsp_t;

endpackage

>>> hw/rtl/ttsp_div.sv
// bit-serial modulo unit: 64-bit hash reduced by the slot count, one bit per cycle
module ttsp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttsp_pkg::div_req_t  req_i,
  output ttsp_pkg::div_rsp_t  rsp_o
);
  import ttsp_pkg::*;

  logic              busy_q, busy_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [HashW-1:0]  dvd_q, dvd_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic              done_q, done_d;
  logic [CountW:0]   trial;

  assign trial = {rem_q, dvd_q[HashW-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd63;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[HashW-2:0], 1'b0};
      // remainder stays below the divisor, so the trial fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CountW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = CountW'(trial);
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hw/rtl/ttsp_mem.sv
// single-port slot memory with registered read data
module ttsp_mem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [127:0]     wdata_i,
  output logic [127:0]     rdata_o
);

  logic [127:0] mem [Depth];
  logic [127:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/transposition_table_store_probe_unit.sv
// Direct-mapped transposition table: store-if-better, probe and clear over one slot memory.
// Each request gives one result beat. A store or probe first reduces the hash by the slot
// count in the bit-serial divider (64 steps and the registered remainder), then reads the
// memory, then compares and writes back. A result register that is still full holds the
// compare until it frees. The next request is taken the cycle after the result is loaded.
// A clear walks the memory one slot per cycle over all ENTRIES slots, then answers with an
// all-zero slot. After reset the same walk over all slots runs before the first request is taken;
// configuration writes are taken at any time. The next request is taken while a result
// still waits on the master side.
module transposition_table_store_probe_unit #(
  parameter int unsigned ENTRIES = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // hash, search_depth, score, best_move, node_kind, generation
  input  logic [1:0]   s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // written, slot_key, slot_depth, slot_score, slot_move, slot_kind, slot_age, zero fill
  output logic [135:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ttsp_pkg::*;

  localparam int unsigned AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AddrW-1:0] LastSlot = AddrW'(ENTRIES - 1);

  state_e            state_q, state_d;
  logic [CountW-1:0] cfg_q;
  logic [CountW-1:0] slots;
  req_t              req_q;
  logic              reply_q, reply_d;
  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [AddrW-1:0]  idx;
  logic              out_valid_q;
  logic              out_written_q;
  entry_t            out_entry_q;
  logic              out_free;
  logic              in_fire;
  logic              cfg_wr;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              mem_re, mem_we;
  logic [AddrW-1:0]  mem_addr;
  entry_t            mem_wdata, slot;
  logic [127:0]      mem_rdata;

  logic              better;
  logic              out_load;
  logic              out_written;
  entry_t            out_entry;
  entry_t            new_entry;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? {{(32-CountW){1'b0}}, cfg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CountW'(65536);
    end else if (cfg_wr) begin
      cfg_q <= pwdata[CountW-1:0];
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      slots = CountW'(1);
    end else if (32'(cfg_q) > 32'(ENTRIES)) begin
      slots = CountW'(ENTRIES);
    end else begin
      slots = cfg_q;
    end
  end

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign idx      = AddrW'(div_rsp.rem);
  assign slot     = entry_t'(mem_rdata);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.op           <= op_e'(s_axis_tuser);
      req_q.hash         <= s_axis_tdata[63:0];
      req_q.search_depth <= s_axis_tdata[79:64];
      req_q.score        <= s_axis_tdata[95:80];
      req_q.best_move    <= s_axis_tdata[111:96];
      req_q.node_kind    <= s_axis_tdata[119:112];
      req_q.generation   <= s_axis_tdata[127:120];
    end
  end

  ttsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ttsp_mem #(
    .Depth (ENTRIES),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // slot index is captured from the divider on done and held until the next done
  logic [AddrW-1:0] idx_q;
  always_ff @(posedge clk_i) begin
    if (div_rsp.done) begin
      idx_q <= idx;
    end
  end

  assign better = (slot.age < req_q.generation) || (slot.depth < req_q.search_depth);

  always_comb begin
    new_entry.key   = req_q.hash;
    new_entry.depth = req_q.search_depth;
    new_entry.score = req_q.score;
    new_entry.move  = req_q.best_move;
    new_entry.kind  = req_q.node_kind;
    new_entry.age   = req_q.generation;
  end

  // next state
  always_comb begin
    state_d   = state_q;
    reply_d   = reply_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == LastSlot) begin
          clr_cnt_d = '0;
          state_d   = reply_q ? ST_ZERO : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (op_e'(s_axis_tuser) == OP_CLEAR) begin
            state_d = ST_CLR;
            reply_d = 1'b1;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_CMP;
      ST_CMP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = req_q.hash;
    div_req.divisor  = slots;
    mem_re           = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = idx_q;
    mem_wdata        = new_entry;
    out_load         = 1'b0;
    out_written      = 1'b0;
    out_entry        = slot;
    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready    = 1'b1;
        div_req.start    = in_fire && (op_e'(s_axis_tuser) != OP_CLEAR);
        div_req.dividend = s_axis_tdata[63:0];
      end
      ST_RD: mem_re = 1'b1;
      ST_CMP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (req_q.op == OP_STORE && better) begin
            mem_we      = 1'b1;
            out_written = 1'b1;
            out_entry   = new_entry;
          end
        end
      end
      ST_ZERO: begin
        out_load  = out_free;
        out_entry = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      reply_q     <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      reply_q   <= (state_q == ST_ZERO) ? 1'b0 : reply_d;
      clr_cnt_q <= clr_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_written_q <= out_written;
      out_entry_q   <= out_entry;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_entry_q, out_written_q};

`ifndef ASSERT_OFF
  a_write_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && mem_we) |=> (m_axis_tvalid && m_axis_tdata[0]))
    else $error("store write-back not flagged in result");
  a_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("request taken during clearing pass");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("modulo result outside division phase");
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (div_rsp.rem < slots))
    else $error("slot index not below slot count");
  a_zero_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ZERO && out_free) |=> (m_axis_tdata == '0))
    else $error("clear result not all zero");
`endif

endmodule
